// ===== src/bilinear_rescale_palette_retint_macros.svh =====
// Assertion macros used by the port-level checker of the bilinear rescaler.
`ifndef BILINEAR_RESCALE_PALETTE_RETINT_MACROS_SVH
`define BILINEAR_RESCALE_PALETTE_RETINT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BRP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/brp_pkg.sv =====
// Shared constants, types and helpers of the bilinear rescaler.
package brp_pkg;

	localparam int SRC_DEPTH  = 1048576;
	localparam int SRC_AW     = 20;
	localparam int BASE_DEPTH = 65536;
	localparam int BASE_AW    = 16;
	localparam int PAL_SIZE   = 256;
	localparam int PAL_AW     = 8;

	localparam int PIX_W      = 32;
	localparam int COL_W      = 24;
	localparam int IDX_W      = 8;
	localparam int ADDR_W     = 20;
	localparam int COORD_W    = 12;
	localparam int FUNC_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DIM_W      = 10;
	localparam int SCALE_W    = 4;

	localparam int STEP_W     = 5;   // 2k, up to 30
	localparam int WGT_W      = 10;  // product of two axis weights, up to 900
	localparam int SPAN_W     = 14;  // source frame extent, up to 1023*15
	localparam int NX_W       = 18;  // signed doubled centre coordinate
	localparam int ACC_W      = 18;  // weighted channel sum
	localparam int LANES      = 4;
	localparam int NUM_W      = 19;
	localparam int DEN_W      = 11;
	localparam int DIV_CNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SRC    = 3'd0,
		FUNC_BASE   = 3'd1,
		FUNC_REF    = 3'd2,
		FUNC_CUR    = 3'd3,
		FUNC_RENDER = 3'd4
	} func_t;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_ENABLE = 3'd4;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_op_t;

	typedef struct packed {
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_res_t;

	function automatic logic [7:0] sat8(input logic [NUM_W-1:0] v);
		sat8 = (v > NUM_W'(255)) ? 8'hFF : v[7:0];
	endfunction

endpackage

// ===== src/brp_if.sv =====
// Request and response channel interfaces of the bilinear rescaler.
interface brp_req_if;
	logic                        valid;
	logic                        ready;
	logic [brp_pkg::FUNC_W-1:0]  func;
	logic [brp_pkg::ADDR_W-1:0]  address;
	logic [brp_pkg::PIX_W-1:0]   data;
	logic [brp_pkg::COORD_W-1:0] out_x;
	logic [brp_pkg::COORD_W-1:0] out_y;

	modport source(output valid, func, address, data, out_x, out_y, input ready);
	modport sink(input valid, func, address, data, out_x, out_y, output ready);
endinterface

interface brp_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [brp_pkg::PIX_W-1:0] pixel;
	logic                      range_error;

	modport source(output valid, pixel, range_error, input ready);
	modport sink(input valid, pixel, range_error, output ready);
endinterface

// ===== src/brp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module brp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/brp_div.sv =====
// Four-lane restoring divider, one quotient bit per lane per cycle.
module brp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  brp_pkg::div_op_t  op  [brp_pkg::LANES],
	output logic              done,
	output brp_pkg::div_res_t res [brp_pkg::LANES]
);

	logic                          busy_q;
	logic                          done_q;
	logic [brp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [brp_pkg::NUM_W-1:0]     num_q [brp_pkg::LANES];
	logic [brp_pkg::DEN_W-1:0]     den_q [brp_pkg::LANES];
	logic [brp_pkg::DEN_W-1:0]     rem_q [brp_pkg::LANES];
	logic [brp_pkg::NUM_W-1:0]     num_nx [brp_pkg::LANES];
	logic [brp_pkg::DEN_W-1:0]     rem_nx [brp_pkg::LANES];

	always_comb begin
		for (int l = 0; l < brp_pkg::LANES; l++) begin
			logic [brp_pkg::DEN_W:0] trial;
			logic                    ge;
			trial     = {rem_q[l], num_q[l][brp_pkg::NUM_W-1]};
			ge        = trial >= {1'b0, den_q[l]};
			rem_nx[l] = ge ? brp_pkg::DEN_W'(trial - {1'b0, den_q[l]})
				: trial[brp_pkg::DEN_W-1:0];
			num_nx[l] = {num_q[l][brp_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start
				&& (cnt_q == brp_pkg::DIV_CNT_W'(brp_pkg::NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == brp_pkg::DIV_CNT_W'(brp_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < brp_pkg::LANES; l++) begin
			if (start) begin
				num_q[l] <= op[l].num;
				den_q[l] <= op[l].den;
				rem_q[l] <= '0;
			end else if (busy_q) begin
				num_q[l] <= num_nx[l];
				rem_q[l] <= rem_nx[l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < brp_pkg::LANES; l++) begin
			res[l].quo = num_q[l];
			res[l].rem = rem_q[l];
		end
	end

	assign done = done_q;

endmodule

// ===== src/bilinear_rescale_palette_retint.sv =====
// Top level of the bilinear rescaler with palette retint.
// Four stores sit in synchronous RAMs: source pixels (ARGB, source scale,
// row major), base palette indices, and the reference and current palettes.
// Request func 0..3 writes one entry and is taken with no response whenever
// the block is idle; func 4 renders one output pixel and gives one response;
// codes 5..7 are taken and dropped. A render runs one item at a time: a
// geometry step, one pass of the shared four-lane divider for the centre
// position and the base pixel, four back-to-back reads of the source RAM
// (one neighbor per cycle, the single read port sets this), one divider pass
// for the rounding of all four channels, and with tint enabled one more
// divider pass for the color ratio. The request side stays blocked until the
// render is done, longer if the previous response still waits in the output
// register; an out-of-frame render skips the computation and answers with
// pixel zero and range_error set. The response sits in an output register,
// so writes keep flowing while a result waits. Configuration is taken
// through cfg_we / cfg_index / cfg_data; a zero scale acts as one. Store
// contents are undefined until written; there is no clearing pass.
module bilinear_rescale_palette_retint (
	input  logic                           clk,
	input  logic                           arst_n,
	brp_req_if.sink                        req,
	brp_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [brp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brp_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEO,
		S_DIV1,
		S_CLAMP,
		S_ADDR,
		S_READ,
		S_DIV2,
		S_TMUL,
		S_DIV3,
		S_DONE
	} state_t;

	// Configuration registers
	logic [brp_pkg::DIM_W-1:0]   bw_q, bh_q;
	logic [brp_pkg::SCALE_W-1:0] ss_q, os_q;
	logic                        tint_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q   <= brp_pkg::DIM_W'(1);
			bh_q   <= brp_pkg::DIM_W'(1);
			ss_q   <= brp_pkg::SCALE_W'(1);
			os_q   <= brp_pkg::SCALE_W'(1);
			tint_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				brp_pkg::REG_BASE_WIDTH:  bw_q   <= cfg_data;
				brp_pkg::REG_BASE_HEIGHT: bh_q   <= cfg_data;
				brp_pkg::REG_SRC_SCALE:   ss_q   <= cfg_data[brp_pkg::SCALE_W-1:0];
				brp_pkg::REG_OUT_SCALE:   os_q   <= cfg_data[brp_pkg::SCALE_W-1:0];
				brp_pkg::REG_TINT_ENABLE: tint_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Zero scale behaves as one; d = 2k is the weight denominator per axis
	logic [brp_pkg::SCALE_W-1:0] s_eff, k_eff;
	logic [brp_pkg::STEP_W-1:0]  d;
	assign s_eff = (ss_q == '0) ? brp_pkg::SCALE_W'(1) : ss_q;
	assign k_eff = (os_q == '0) ? brp_pkg::SCALE_W'(1) : os_q;
	assign d     = {k_eff, 1'b0};

	state_t state_q;
	logic   start_q;
	logic   rsp_v_q;
	logic [2:0] rd_q;

	logic accept;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// Frame check at the request: out of frame when x >= w*k or y >= h*k
	logic [brp_pkg::SPAN_W-1:0] fw, fh;
	logic                       oof;
	assign fw  = brp_pkg::SPAN_W'(bw_q) * brp_pkg::SPAN_W'(k_eff);
	assign fh  = brp_pkg::SPAN_W'(bh_q) * brp_pkg::SPAN_W'(k_eff);
	assign oof = (brp_pkg::SPAN_W'(req.out_x) >= fw) || (brp_pkg::SPAN_W'(req.out_y) >= fh);

	// Store write ports, straight from the request
	logic is_src, is_base, is_ref, is_cur, is_render;
	assign is_src    = req.func == brp_pkg::FUNC_SRC;
	assign is_base   = req.func == brp_pkg::FUNC_BASE;
	assign is_ref    = req.func == brp_pkg::FUNC_REF;
	assign is_cur    = req.func == brp_pkg::FUNC_CUR;
	assign is_render = req.func == brp_pkg::FUNC_RENDER;

	// Render payload registers
	logic [brp_pkg::COORD_W-1:0] ox_q, oy_q;
	logic                        err_q;
	logic [brp_pkg::NX_W-1:0]    nx_q, ny_q;
	logic [brp_pkg::SPAN_W-1:0]  sw_q, x0_q, x1_q, y0_q, y1_q;
	logic [brp_pkg::STEP_W-1:0]  tx_q, ty_q;
	logic [brp_pkg::COORD_W-1:0] bx_q, by_q;
	logic [brp_pkg::SRC_AW-1:0]  rb0_q, rb1_q;
	logic [brp_pkg::BASE_AW-1:0] baddr_q;
	logic [brp_pkg::WGT_W-1:0]   w_q [4];
	logic [brp_pkg::WGT_W-1:0]   dd_q;
	logic [brp_pkg::ACC_W-1:0]   acc_q [4];
	logic [brp_pkg::PIX_W-1:0]   px_q;
	logic [brp_pkg::NUM_W-1:0]   tnum_q [3];
	logic [brp_pkg::DEN_W-1:0]   tden_q [3];
	logic [brp_pkg::PIX_W-1:0]   pix_q;
	logic                        rerr_q;

	// Memories
	logic                        src_re, base_re, pal_re;
	logic [brp_pkg::SRC_AW-1:0]  src_raddr;
	logic [brp_pkg::PIX_W-1:0]   src_rdata;
	logic [brp_pkg::IDX_W-1:0]   base_rdata;
	logic [brp_pkg::COL_W-1:0]   ref_rdata, cur_rdata;

	brp_ram #(.WIDTH(brp_pkg::PIX_W), .DEPTH(brp_pkg::SRC_DEPTH)) u_src_ram (
		.clk  (clk),
		.we   (accept && is_src),
		.waddr(req.address[brp_pkg::SRC_AW-1:0]),
		.wdata(req.data),
		.re   (src_re),
		.raddr(src_raddr),
		.rdata(src_rdata)
	);

	brp_ram #(.WIDTH(brp_pkg::IDX_W), .DEPTH(brp_pkg::BASE_DEPTH)) u_base_ram (
		.clk  (clk),
		.we   (accept && is_base),
		.waddr(req.address[brp_pkg::BASE_AW-1:0]),
		.wdata(req.data[brp_pkg::IDX_W-1:0]),
		.re   (base_re),
		.raddr(baddr_q),
		.rdata(base_rdata)
	);

	brp_ram #(.WIDTH(brp_pkg::COL_W), .DEPTH(brp_pkg::PAL_SIZE)) u_ref_ram (
		.clk  (clk),
		.we   (accept && is_ref),
		.waddr(req.address[brp_pkg::PAL_AW-1:0]),
		.wdata(req.data[brp_pkg::COL_W-1:0]),
		.re   (pal_re),
		.raddr(base_rdata),
		.rdata(ref_rdata)
	);

	brp_ram #(.WIDTH(brp_pkg::COL_W), .DEPTH(brp_pkg::PAL_SIZE)) u_cur_ram (
		.clk  (clk),
		.we   (accept && is_cur),
		.waddr(req.address[brp_pkg::PAL_AW-1:0]),
		.wdata(req.data[brp_pkg::COL_W-1:0]),
		.re   (pal_re),
		.raddr(base_rdata),
		.rdata(cur_rdata)
	);

	// Neighbor order on rd_q: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
	// The base index comes back after the first read and addresses both palettes.
	assign src_re    = (state_q == S_READ) && !rd_q[2];
	assign base_re   = (state_q == S_READ) && (rd_q == 3'd0);
	assign pal_re    = (state_q == S_READ) && (rd_q == 3'd1);
	assign src_raddr = (rd_q[1] ? rb1_q : rb0_q)
		+ brp_pkg::SRC_AW'(rd_q[0] ? x1_q : x0_q);

	// Shared divider
	brp_pkg::div_op_t  div_op  [brp_pkg::LANES];
	brp_pkg::div_res_t div_res [brp_pkg::LANES];
	logic              div_done;
	logic              xneg, yneg;

	assign xneg = nx_q[brp_pkg::NX_W-1];
	assign yneg = ny_q[brp_pkg::NX_W-1];

	always_comb begin
		for (int l = 0; l < brp_pkg::LANES; l++) begin
			div_op[l].num = '0;
			div_op[l].den = brp_pkg::DEN_W'(1);
		end
		case (state_q)
			S_DIV1: begin
				// Centre position over 2k, and base pixel over k
				div_op[0].num = xneg ? '0 : brp_pkg::NUM_W'(nx_q);
				div_op[0].den = brp_pkg::DEN_W'(d);
				div_op[1].num = yneg ? '0 : brp_pkg::NUM_W'(ny_q);
				div_op[1].den = brp_pkg::DEN_W'(d);
				div_op[2].num = brp_pkg::NUM_W'(ox_q);
				div_op[2].den = brp_pkg::DEN_W'(k_eff);
				div_op[3].num = brp_pkg::NUM_W'(oy_q);
				div_op[3].den = brp_pkg::DEN_W'(k_eff);
			end
			S_DIV2: begin
				// Round half up: (2n + D) / (2D)
				for (int l = 0; l < brp_pkg::LANES; l++) begin
					div_op[l].num = brp_pkg::NUM_W'({acc_q[l], 1'b0}) + brp_pkg::NUM_W'(dd_q);
					div_op[l].den = brp_pkg::DEN_W'({dd_q, 1'b0});
				end
			end
			S_DIV3: begin
				for (int l = 0; l < 3; l++) begin
					div_op[l].num = tnum_q[l];
					div_op[l].den = tden_q[l];
				end
			end
			default: ;
		endcase
	end

	brp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.op    (div_op),
		.done  (div_done),
		.res   (div_res)
	);

	// Clamp of the neighbor coordinates to the source frame
	logic [brp_pkg::SPAN_W-1:0] sw, sh, sw_m1, sh_m1;
	logic [brp_pkg::SPAN_W-1:0] x0c, x1c, y0c, y1c;
	logic [brp_pkg::NUM_W-1:0]  qx1, qy1;
	logic [brp_pkg::STEP_W-1:0] txc, tyc;

	always_comb begin
		sw    = brp_pkg::SPAN_W'(bw_q) * brp_pkg::SPAN_W'(s_eff);
		sh    = brp_pkg::SPAN_W'(bh_q) * brp_pkg::SPAN_W'(s_eff);
		sw_m1 = sw - 1'b1;
		sh_m1 = sh - 1'b1;
		qx1   = div_res[0].quo + 1'b1;
		qy1   = div_res[1].quo + 1'b1;
		x0c   = (div_res[0].quo > brp_pkg::NUM_W'(sw_m1)) ? sw_m1
			: div_res[0].quo[brp_pkg::SPAN_W-1:0];
		x1c   = (qx1 > brp_pkg::NUM_W'(sw_m1)) ? sw_m1 : qx1[brp_pkg::SPAN_W-1:0];
		y0c   = (div_res[1].quo > brp_pkg::NUM_W'(sh_m1)) ? sh_m1
			: div_res[1].quo[brp_pkg::SPAN_W-1:0];
		y1c   = (qy1 > brp_pkg::NUM_W'(sh_m1)) ? sh_m1 : qy1[brp_pkg::SPAN_W-1:0];
		// A negative centre lies between -1 and 0: both neighbors clamp to 0
		if (xneg) begin
			x0c = '0;
			x1c = '0;
		end
		if (yneg) begin
			y0c = '0;
			y1c = '0;
		end
		txc = xneg ? brp_pkg::STEP_W'(nx_q + brp_pkg::NX_W'(d))
			: div_res[0].rem[brp_pkg::STEP_W-1:0];
		tyc = yneg ? brp_pkg::STEP_W'(ny_q + brp_pkg::NX_W'(d))
			: div_res[1].rem[brp_pkg::STEP_W-1:0];
	end

	// Row bases and base index address
	logic [2*brp_pkg::SPAN_W-1:0]    rb0_full, rb1_full;
	logic [brp_pkg::COORD_W+brp_pkg::DIM_W-1:0] bfull;
	logic [brp_pkg::STEP_W-1:0]      wx0, wy0;

	assign rb0_full = (2*brp_pkg::SPAN_W)'(y0_q) * (2*brp_pkg::SPAN_W)'(sw_q);
	assign rb1_full = (2*brp_pkg::SPAN_W)'(y1_q) * (2*brp_pkg::SPAN_W)'(sw_q);
	assign bfull    = (brp_pkg::COORD_W+brp_pkg::DIM_W)'(by_q)
		* (brp_pkg::COORD_W+brp_pkg::DIM_W)'(bw_q)
		+ (brp_pkg::COORD_W+brp_pkg::DIM_W)'(bx_q);
	assign wx0      = d - tx_q;
	assign wy0      = d - ty_q;

	logic [1:0]                sel;
	logic [brp_pkg::WGT_W-1:0] w_sel;
	assign sel   = 2'(rd_q - 3'd1);
	assign w_sel = w_q[sel];

	// Control: state, divider start, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			rsp_v_q <= 1'b0;
			rd_q    <= '0;
		end else begin
			// Pulse the divider start on entry to each divider state
			start_q <= (state_q == S_GEO) || (state_q == S_TMUL)
				|| ((state_q == S_READ) && (rd_q == 3'd4));
			// Load the output register from S_DONE, drop it once taken
			if ((state_q == S_DONE) && (!rsp_v_q || rsp.ready)) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && is_render) begin
						state_q <= oof ? S_DONE : S_GEO;
					end
				end
				S_GEO: state_q <= S_DIV1;
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: state_q <= S_ADDR;
				S_ADDR: begin
					state_q <= S_READ;
					rd_q    <= '0;
				end
				S_READ: begin
					rd_q <= rd_q + 1'b1;
					if (rd_q == 3'd4) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= tint_q ? S_TMUL : S_DONE;
					end
				end
				S_TMUL: state_q <= S_DIV3;
				S_DIV3: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (!rsp_v_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ox_q  <= req.out_x;
				oy_q  <= req.out_y;
				err_q <= oof;
			end
			S_GEO: begin
				// Doubled centre: (2x+1)*s - k
				nx_q <= brp_pkg::NX_W'({ox_q, 1'b1}) * brp_pkg::NX_W'(s_eff)
					- brp_pkg::NX_W'(k_eff);
				ny_q <= brp_pkg::NX_W'({oy_q, 1'b1}) * brp_pkg::NX_W'(s_eff)
					- brp_pkg::NX_W'(k_eff);
			end
			S_CLAMP: begin
				sw_q <= sw;
				x0_q <= x0c;
				x1_q <= x1c;
				y0_q <= y0c;
				y1_q <= y1c;
				tx_q <= txc;
				ty_q <= tyc;
				bx_q <= div_res[2].quo[brp_pkg::COORD_W-1:0];
				by_q <= div_res[3].quo[brp_pkg::COORD_W-1:0];
			end
			S_ADDR: begin
				rb0_q   <= rb0_full[brp_pkg::SRC_AW-1:0];
				rb1_q   <= rb1_full[brp_pkg::SRC_AW-1:0];
				baddr_q <= bfull[brp_pkg::BASE_AW-1:0];
				w_q[0]  <= brp_pkg::WGT_W'(wx0) * brp_pkg::WGT_W'(wy0);
				w_q[1]  <= brp_pkg::WGT_W'(tx_q) * brp_pkg::WGT_W'(wy0);
				w_q[2]  <= brp_pkg::WGT_W'(wx0) * brp_pkg::WGT_W'(ty_q);
				w_q[3]  <= brp_pkg::WGT_W'(tx_q) * brp_pkg::WGT_W'(ty_q);
				dd_q    <= brp_pkg::WGT_W'(d) * brp_pkg::WGT_W'(d);
				for (int c = 0; c < 4; c++) begin
					acc_q[c] <= '0;
				end
			end
			S_READ: begin
				// Accumulate the neighbor read in the previous cycle
				if (rd_q != 3'd0) begin
					for (int c = 0; c < 4; c++) begin
						acc_q[c] <= acc_q[c] + brp_pkg::ACC_W'(src_rdata[8*c +: 8])
							* brp_pkg::ACC_W'(w_sel);
					end
				end
			end
			S_DIV2: begin
				if (div_done) begin
					for (int c = 0; c < 4; c++) begin
						px_q[8*c +: 8] <= brp_pkg::sat8(div_res[c].quo);
					end
				end
			end
			S_TMUL: begin
				// (2*c*(cur+1) + ref+1) / (2*(ref+1))
				for (int c = 0; c < 3; c++) begin
					logic [8:0] cur1, ref1;
					cur1      = 9'(cur_rdata[8*c +: 8]) + 9'd1;
					ref1      = 9'(ref_rdata[8*c +: 8]) + 9'd1;
					tnum_q[c] <= brp_pkg::NUM_W'({px_q[8*c +: 8], 1'b0})
						* brp_pkg::NUM_W'(cur1) + brp_pkg::NUM_W'(ref1);
					tden_q[c] <= brp_pkg::DEN_W'({ref1, 1'b0});
				end
			end
			S_DIV3: begin
				if (div_done) begin
					for (int c = 0; c < 3; c++) begin
						px_q[8*c +: 8] <= brp_pkg::sat8(div_res[c].quo);
					end
				end
			end
			S_DONE: begin
				if (!rsp_v_q || rsp.ready) begin
					pix_q  <= err_q ? '0 : px_q;
					rerr_q <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.pixel       = pix_q;
	assign rsp.range_error = rerr_q;

endmodule

// ===== src/brp_checker.sv =====
// Port-level assertions of the bilinear rescaler and their bind.
`include "bilinear_rescale_palette_retint_macros.svh"

module brp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic [brp_pkg::FUNC_W-1:0] req_func,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [brp_pkg::PIX_W-1:0]  rsp_pixel,
	input logic                       rsp_range_error
);

	// A stalled response holds its payload
	`BRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel) && $stable(rsp_range_error), "response changed while stalled")

	// An out-of-frame response carries a zero pixel
	`BRP_ASSERT_SAME(a_err_zero, rsp_valid && rsp_range_error, rsp_pixel == '0, "range error with nonzero pixel")

	// A render occupies the block in the next cycle
	`BRP_ASSERT_NEXT(a_render_busy, req_valid && req_ready && req_func == brp_pkg::FUNC_RENDER, !req_ready, "ready right after a render request")

	// Only a render request takes the block away from the request side
	`BRP_ASSERT_SAME(a_busy_cause, $fell(req_ready), $past(req_valid && req_func == brp_pkg::FUNC_RENDER), "request side blocked without a render")

endmodule

bind bilinear_rescale_palette_retint brp_checker u_brp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_func       (req.func),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_pixel      (rsp.pixel),
	.rsp_range_error(rsp.range_error)
);

// ===== tb/sv/brp_checker.sv =====
// Checker for the bilinear rescaler: mirrors the stores, predicts responses, compares.
`timescale 1ns / 1ps

module brp_tb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	brp_req_if                             req,
	brp_rsp_if                             rsp,
	input  logic                           cfg_we,
	input  logic [brp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import brp_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             range_error;
	} pixel_rsp_t;

	pixel_rsp_t       pixel_queue[$];
	logic [PIX_W-1:0] src_mem[int];
	logic [IDX_W-1:0] base_mem[int];
	logic [COL_W-1:0] ref_pal[PAL_SIZE];
	logic [COL_W-1:0] cur_pal[PAL_SIZE];

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SCALE_W-1:0] src_scale_q;
	logic [SCALE_W-1:0] out_scale_q;
	logic               tint_q;

	function automatic logic [PIX_W-1:0] src_read(longint row, longint col, longint w);
		int a;
		a = int'((row * w + col) & (SRC_DEPTH - 1));
		return src_mem.exists(a) ? src_mem[a] : '0;
	endfunction

	function automatic logic [7:0] retint(int c, int r, int cu);
		int v;
		v = (2 * c * (cu + 1) + r + 1) / (2 * (r + 1));
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	function automatic pixel_rsp_t predict_pixel(int ox, int oy);
		pixel_rsp_t res;
		longint s, k, sw, sh, d, nx, ny, x0, y0, tx, ty, x1, y1, n, dd, c;
		logic [PIX_W-1:0] p00, p10, p01, p11, px;
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] rc, cc;
		int bi;
		s = (src_scale_q == 0) ? 1 : src_scale_q;
		k = (out_scale_q == 0) ? 1 : out_scale_q;
		res.pixel = '0;
		res.range_error = 1'b1;
		if (ox >= width_q * k || oy >= height_q * k)
			return res;
		res.range_error = 1'b0;
		sw = width_q * s;
		sh = height_q * s;
		d = 2 * k;
		nx = (2 * ox + 1) * s - k;
		ny = (2 * oy + 1) * s - k;
		x0 = (nx >= 0) ? nx / d : -((-nx + d - 1) / d);
		y0 = (ny >= 0) ? ny / d : -((-ny + d - 1) / d);
		tx = nx - x0 * d;
		ty = ny - y0 * d;
		x1 = (x0 + 1 < sw - 1) ? x0 + 1 : sw - 1;
		y1 = (y0 + 1 < sh - 1) ? y0 + 1 : sh - 1;
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x0 > sw - 1) x0 = sw - 1;
		if (y0 > sh - 1) y0 = sh - 1;
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		p00 = src_read(y0, x0, sw);
		p10 = src_read(y0, x1, sw);
		p01 = src_read(y1, x0, sw);
		p11 = src_read(y1, x1, sw);
		dd = d * d;
		px = '0;
		for (int lane = 0; lane < 4; lane++) begin
			n = longint'(p00[lane*8 +: 8]) * (d - tx) * (d - ty)
			  + longint'(p10[lane*8 +: 8]) * tx * (d - ty)
			  + longint'(p01[lane*8 +: 8]) * (d - tx) * ty
			  + longint'(p11[lane*8 +: 8]) * tx * ty;
			c = (2 * n + dd) / (2 * dd);
			px[lane*8 +: 8] = (c > 255) ? 8'hFF : c[7:0];
		end
		if (tint_q) begin
			bi = int'((longint'(oy / k) * width_q + ox / k) & (BASE_DEPTH - 1));
			idx = base_mem.exists(bi) ? base_mem[bi] : '0;
			rc = ref_pal[idx];
			cc = cur_pal[idx];
			for (int lane = 0; lane < 3; lane++)
				px[lane*8 +: 8] = retint(px[lane*8 +: 8], rc[lane*8 +: 8], cc[lane*8 +: 8]);
		end
		res.pixel = px;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
		for (int i = 0; i < PAL_SIZE; i++) begin
			ref_pal[i] = '0;
			cur_pal[i] = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 1;
			height_q    <= 1;
			src_scale_q <= 1;
			out_scale_q <= 1;
			tint_q      <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_WIDTH:  width_q     <= cfg_data;
					REG_BASE_HEIGHT: height_q    <= cfg_data;
					REG_SRC_SCALE:   src_scale_q <= cfg_data[SCALE_W-1:0];
					REG_OUT_SCALE:   out_scale_q <= cfg_data[SCALE_W-1:0];
					REG_TINT_ENABLE: tint_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (pixel_queue.size() == 0) begin
					report_mismatch("unexpected response", rsp.pixel, '0);
				end else begin
					if (rsp.pixel !== pixel_queue[0].pixel)
						report_mismatch("pixel", rsp.pixel, pixel_queue[0].pixel);
					if (rsp.range_error !== pixel_queue[0].range_error)
						report_mismatch("range_error", PIX_W'(rsp.range_error),
							PIX_W'(pixel_queue[0].range_error));
					void'(pixel_queue.pop_front());
				end
			end
			if (req.valid && req.ready) begin
				case (req.func)
					FUNC_SRC:    src_mem[int'(req.address)] = req.data;
					FUNC_BASE:   base_mem[int'(req.address[BASE_AW-1:0])] = req.data[7:0];
					FUNC_REF:    ref_pal[req.address[PAL_AW-1:0]] = req.data[COL_W-1:0];
					FUNC_CUR:    cur_pal[req.address[PAL_AW-1:0]] = req.data[COL_W-1:0];
					FUNC_RENDER: pixel_queue = {pixel_queue,
						predict_pixel(int'(req.out_x), int'(req.out_y))};
					default: ;
				endcase
			end
			pending = pixel_queue.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the bilinear rescaler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import brp_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;

	brp_req_if req ();
	brp_rsp_if rsp ();

	bilinear_rescale_palette_retint dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	brp_tb_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// Drain window, chosen longer than the slowest render.
	localparam int DRAIN_CYCLES = 80;

	// Local copy of the configuration, used only to pick coordinates and to
	// know which store entries a render will read.
	int width_cfg, height_cfg, src_scale_cfg, out_scale_cfg, tint_cfg;
	bit src_seen[int];
	logic [IDX_W-1:0] base_val[int];
	bit ref_seen[int];
	bit cur_seen[int];
	bit quiet;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[bilinear_rescale_palette_retint] ERROR");
		$finish;
	end

	// Response side: stall in random bursts, always ready once the run goes quiet.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Present one request from the falling edge and hold it until taken.
	task automatic send_request(func_t f, logic [ADDR_W-1:0] a, logic [PIX_W-1:0] d,
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		logic taken;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid   = 1'b1;
		req.func    = f;
		req.address = a;
		req.data    = d;
		req.out_x   = x;
		req.out_y   = y;
		do begin
			@(posedge clk);
			taken = req.ready;
			@(negedge clk);
		end while (!taken);
		if (f == FUNC_SRC)
			src_seen[int'(a)] = 1'b1;
		if (f == FUNC_BASE)
			base_val[int'(a[BASE_AW-1:0])] = d[IDX_W-1:0];
		if (f == FUNC_REF)
			ref_seen[int'(a[PAL_AW-1:0])] = 1'b1;
		if (f == FUNC_CUR)
			cur_seen[int'(a[PAL_AW-1:0])] = 1'b1;
	endtask

	// Write a source entry first if the render would read it unwritten.
	task automatic cover_source(longint row, longint col, longint w);
		int a;
		a = int'((row * w + col) & (SRC_DEPTH - 1));
		if (!src_seen.exists(a))
			send_request(FUNC_SRC, ADDR_W'(a), $urandom, '0, '0);
	endtask

	// Render one pixel, writing beforehand every store entry it will read.
	task automatic render_pixel(int ox, int oy);
		longint s, k, sw, sh, d, nx, ny, x0, y0, x1, y1;
		int bi;
		int idx;
		s = (src_scale_cfg == 0) ? 1 : src_scale_cfg;
		k = (out_scale_cfg == 0) ? 1 : out_scale_cfg;
		if (ox < width_cfg * k && oy < height_cfg * k) begin
			sw = width_cfg * s;
			sh = height_cfg * s;
			d = 2 * k;
			nx = (2 * ox + 1) * s - k;
			ny = (2 * oy + 1) * s - k;
			x0 = (nx >= 0) ? nx / d : -((-nx + d - 1) / d);
			y0 = (ny >= 0) ? ny / d : -((-ny + d - 1) / d);
			x1 = (x0 + 1 < sw - 1) ? x0 + 1 : sw - 1;
			y1 = (y0 + 1 < sh - 1) ? y0 + 1 : sh - 1;
			x0 = (x0 < 0) ? 0 : (x0 > sw - 1) ? sw - 1 : x0;
			y0 = (y0 < 0) ? 0 : (y0 > sh - 1) ? sh - 1 : y0;
			if (x1 < 0) x1 = 0;
			if (y1 < 0) y1 = 0;
			cover_source(y0, x0, sw);
			cover_source(y0, x1, sw);
			cover_source(y1, x0, sw);
			cover_source(y1, x1, sw);
			if (tint_cfg != 0) begin
				bi = int'((longint'(oy / k) * width_cfg + ox / k) & (BASE_DEPTH - 1));
				if (!base_val.exists(bi))
					send_request(FUNC_BASE, ADDR_W'(bi), $urandom, '0, '0);
				// Fill the palette entries the base pixel points at
				idx = int'(base_val[bi]);
				if (!ref_seen.exists(idx))
					send_request(FUNC_REF, ADDR_W'(idx), $urandom, '0, '0);
				if (!cur_seen.exists(idx))
					send_request(FUNC_CUR, ADDR_W'(idx), $urandom, '0, '0);
			end
		end
		send_request(FUNC_RENDER, ADDR_W'($urandom), $urandom, COORD_W'(ox), COORD_W'(oy));
	endtask

	// Hold until every response is in, then let any write still in flight settle.
	task automatic drain;
		req.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Write all registers; scale writes carry junk in the unused upper bits.
	task automatic apply_config(int w, int h, int s, int k, int t);
		drain();
		write_reg(REG_BASE_WIDTH, w);
		write_reg(REG_BASE_HEIGHT, h);
		write_reg(REG_SRC_SCALE, int'({6'($urandom_range(0, 63)), 4'(s)}));
		write_reg(REG_OUT_SCALE, int'({6'($urandom_range(0, 63)), 4'(k)}));
		write_reg(REG_TINT_ENABLE, int'({9'($urandom_range(0, 511)), 1'(t)}));
		width_cfg = w;
		height_cfg = h;
		src_scale_cfg = s;
		out_scale_cfg = k;
		tint_cfg = t;
	endtask

	// Renders, mostly inside the frame, with writes and noise mixed in.
	task automatic random_item;
		int pick, kk;
		kk = (out_scale_cfg == 0) ? 1 : out_scale_cfg;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if ($urandom_range(0, 6) == 0 || width_cfg == 0 || height_cfg == 0)
				render_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
			else
				render_pixel($urandom_range(0, width_cfg * kk - 1),
					$urandom_range(0, height_cfg * kk - 1));
		end else if (pick < 65) begin
			send_request(FUNC_SRC, ADDR_W'($urandom), $urandom,
				COORD_W'($urandom), COORD_W'($urandom));
		end else if (pick < 80) begin
			send_request(FUNC_BASE, ADDR_W'($urandom), $urandom,
				COORD_W'($urandom), COORD_W'($urandom));
		end else if (pick < 87) begin
			send_request(FUNC_REF, ADDR_W'($urandom), $urandom,
				COORD_W'($urandom), COORD_W'($urandom));
		end else if (pick < 94) begin
			send_request(FUNC_CUR, ADDR_W'($urandom), $urandom,
				COORD_W'($urandom), COORD_W'($urandom));
		end else begin
			send_request(func_t'($urandom_range(5, 7)), ADDR_W'($urandom), $urandom,
				COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		quiet       = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		req.valid   = 1'b0;
		req.func    = FUNC_SRC;
		req.address = '0;
		req.data    = '0;
		req.out_x   = '0;
		req.out_y   = '0;
		width_cfg = 1;
		height_cfg = 1;
		src_scale_cfg = 1;
		out_scale_cfg = 1;
		tint_cfg = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: unused codes, a white 1x1 frame, out-of-frame corners.
		send_request(func_t'(5), ADDR_W'($urandom), $urandom, COORD_W'($urandom),
			COORD_W'($urandom));
		send_request(func_t'(6), ADDR_W'($urandom), $urandom, COORD_W'($urandom),
			COORD_W'($urandom));
		send_request(func_t'(7), ADDR_W'($urandom), $urandom, COORD_W'($urandom),
			COORD_W'($urandom));
		send_request(FUNC_SRC, '0, 32'hFFFF_FFFF, '0, '0);
		render_pixel(0, 0);
		render_pixel(1, 0);
		render_pixel(0, 1);
		render_pixel(4095, 4095);

		// Directed: tint that saturates, then tint that drives color down to near zero.
		apply_config(1, 1, 1, 1, 1);
		send_request(FUNC_BASE, '0, 32'hABCD_EF07, '0, '0);
		send_request(FUNC_REF, 20'hFFF07, 32'hFF00_0000, '0, '0);
		send_request(FUNC_CUR, 20'h00007, 32'h00FF_FFFF, '0, '0);
		send_request(FUNC_SRC, '0, 32'h8080_4001, '0, '0);
		render_pixel(0, 0);
		send_request(FUNC_REF, 20'h00007, 32'h00FF_FFFF, '0, '0);
		send_request(FUNC_CUR, 20'h00007, 32'hFF00_0000, '0, '0);
		render_pixel(0, 0);
		send_request(FUNC_SRC, 20'hFFFFF, 32'h0000_0000, '0, '0);

		// Random phases over a spread of settings, extremes included.
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: apply_config(1, 1, 1, 1, 0);
				1: apply_config(3, 2, 2, 3, 1);
				2: apply_config(512, 512, 8, 8, 1);
				3: apply_config(1, 1, 8, 1, 1);
				4: apply_config(5, 4, 1, 8, 0);
				5: apply_config(0, 3, 2, 2, 1);
				6: apply_config(4, 4, 0, 0, 1);
				7: apply_config(1023, 1023, 15, 1, 1);
				default: apply_config($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 1));
			endcase
			if (phase == 7)
				quiet = 1'b1;
			for (int n = 0; n < 20; n++) begin
				random_item();
				// Pause the sender once until the block has answered everything.
				if (phase == 3 && n == 10) begin
					req.valid = 1'b0;
					while (pending != 0)
						@(negedge clk);
				end
			end
		end

		drain();
		if (errors == 0)
			$display("[bilinear_rescale_palette_retint] OK");
		else
			$display("[bilinear_rescale_palette_retint] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/brp_pkg.sv
src/brp_if.sv
src/brp_ram.sv
src/brp_div.sv
src/bilinear_rescale_palette_retint.sv
src/brp_checker.sv
tb/sv/brp_checker.sv
tb/sv/testbench.sv
